FILE: src/flqe_pkg.sv
// Shared types and constants for the facing line quad expander.
package flqe_pkg;

  localparam int unsigned SQRT_STEPS = 32;  // root bits of a 62-bit sum
  localparam int unsigned DIV_STEPS  = 31;  // quotient bits
  localparam int unsigned CMAG_W     = 30;  // reduced cross product magnitude
  localparam int unsigned SUM_W      = 62;
  localparam int unsigned NUM_W      = 61;
  localparam int unsigned DEN_W      = 33;
  localparam int unsigned ROOT_W     = 32;

  typedef enum logic [1:0] {
    CFG_CAM_X = 2'd0,
    CFG_CAM_Y = 2'd1,
    CFG_CAM_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] from_z;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic signed [31:0] to_z;
    logic [30:0]        line_width;
    logic signed [31:0] face_x;
    logic signed [31:0] face_y;
    logic signed [31:0] face_z;
    logic               use_face;
    logic [31:0]        color_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        color_out;
    logic [1:0]         corner;
    logic               last;
  } out_word_t;

  // End points, width and color that ride along the pipe.
  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [30:0]      width;
    logic [31:0]      color;
  } line_t;

  typedef struct packed {
    line_t                   ln;
    logic [2:0]              c_neg;
    logic [2:0][CMAG_W-1:0]  c_mag;
    logic                    c_zero;
  } carry_t;

endpackage

FILE: src/facing_line_quad_expander.sv
// Top level: camera-facing line to six-vertex ribbon expander.
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+-------------------
//  input    | in        | in_valid_i / in_stall_o   | in_word_i (one line)
//  result   | out       | out_valid_o / out_stall_i | out_word_o (vertex)
//  config   | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// A line emits six vertex words, one per cycle while out_stall_i is low, so the
// single result port is what limits the line rate of the block.
// The path to the first vertex runs through the input register, nine arithmetic
// stages, 32 square root stages, one numerator multiply, 31 divide stages.
// Reset clears all valid bits and the camera registers; data regs keep junk.
// The whole pipe advances together; it holds only while its tail word waits
// for the vertex serializer, so a stall neither drops nor repeats a word.
module facing_line_quad_expander (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  flqe_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output flqe_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);
  import flqe_pkg::*;

  // Vertex order over the two triangles.
  localparam logic [5:0][1:0] CornerOrder = {2'd2, 2'd3, 2'd1, 2'd2, 2'd1, 2'd0};

  function automatic logic [32:0] mag33(input logic [32:0] x);
    return x[32] ? 33'(-x) : x;
  endfunction

  function automatic logic [62:0] mag64(input logic [63:0] x);
    logic [63:0] t;
    t = x[63] ? 64'(-x) : x;
    return t[62:0];
  endfunction

  // Common shift so every magnitude is at most 2^31-1, truncating to zero.
  function automatic logic [2:0][31:0] reduce_vec(input logic [2:0][32:0] x);
    logic [2:0][32:0] m;
    logic [32:0]      mx;
    logic [1:0]       k;
    logic [32:0]      r;
    logic [2:0][31:0] res;
    for (int i = 0; i < 3; i++) m[i] = mag33(x[i]);
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    k = mx[32] ? 2'd2 : (mx[31] ? 2'd1 : 2'd0);
    for (int i = 0; i < 3; i++) begin
      r = m[i] >> k;
      res[i] = x[i][32] ? 32'(-r) : r[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] sat32(input logic [32:0] x);
    if (!x[32] && x[31]) return 32'h7FFF_FFFF;
    if (x[32] && !x[31]) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // ---------------- configuration ----------------
  logic [31:0] cam_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CAM_X: cam_q[0] <= cfg_wdata_i;
        CFG_CAM_Y: cam_q[1] <= cfg_wdata_i;
        CFG_CAM_Z: cam_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipe control ----------------
  logic en;
  logic tail_v;
  logic ser_ready;

  assign en         = !tail_v || ser_ready;
  assign in_stall_o = !en;

  logic [9:0] v_q;   // valid of stages 0..9

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[8:0], in_valid_i};
    end
  end

  // Stage 0: input register
  in_word_t s0_q;
  always_ff @(posedge clk_i) begin
    if (en) s0_q <= in_word_i;
  end

  line_t s0_ln;
  assign s0_ln.a     = {s0_q.from_z, s0_q.from_y, s0_q.from_x};
  assign s0_ln.b     = {s0_q.to_z, s0_q.to_y, s0_q.to_x};
  assign s0_ln.width = s0_q.line_width;
  assign s0_ln.color = s0_q.color_in;

  // Stage 1: direction d = to - from, facing vector v = f - from
  logic [2:0][31:0] f_sel;
  logic [2:0][32:0] d1_q, v1_q;
  line_t            ln1_q;

  assign f_sel = s0_q.use_face ? {s0_q.face_z, s0_q.face_y, s0_q.face_x}
                               : {cam_q[2], cam_q[1], cam_q[0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= {s0_ln.b[i][31], s0_ln.b[i]} - {s0_ln.a[i][31], s0_ln.a[i]};
        v1_q[i] <= {f_sel[i][31], f_sel[i]} - {s0_ln.a[i][31], s0_ln.a[i]};
      end
      ln1_q <= s0_ln;
    end
  end

  // Stage 2: bring both vectors into 32 bits
  logic [2:0][31:0] d2_q, v2_q;
  line_t            ln2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q  <= reduce_vec(d1_q);
      v2_q  <= reduce_vec(v1_q);
      ln2_q <= ln1_q;
    end
  end

  // Stage 3: six partial products of v x d
  logic signed [63:0] p3_q [6];
  line_t              ln3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q[0] <= $signed(v2_q[1]) * $signed(d2_q[2]);
      p3_q[1] <= $signed(v2_q[2]) * $signed(d2_q[1]);
      p3_q[2] <= $signed(v2_q[2]) * $signed(d2_q[0]);
      p3_q[3] <= $signed(v2_q[0]) * $signed(d2_q[2]);
      p3_q[4] <= $signed(v2_q[0]) * $signed(d2_q[1]);
      p3_q[5] <= $signed(v2_q[1]) * $signed(d2_q[0]);
      ln3_q   <= ln2_q;
    end
  end

  // Stage 4: cross product, exact
  logic [2:0][63:0] c4_q;
  line_t            ln4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q[0] <= 64'(p3_q[0] - p3_q[1]);
      c4_q[1] <= 64'(p3_q[2] - p3_q[3]);
      c4_q[2] <= 64'(p3_q[4] - p3_q[5]);
      ln4_q   <= ln3_q;
    end
  end

  // Stage 5: magnitudes and their maximum
  logic [2:0][62:0] cm5_q;
  logic [2:0]       cn5_q;
  logic [62:0]      mx5_q;
  line_t            ln5_q;
  logic [2:0][62:0] cm5_d;
  logic [62:0]      mx5_d;

  always_comb begin
    for (int i = 0; i < 3; i++) cm5_d[i] = mag64(c4_q[i]);
    mx5_d = cm5_d[0];
    if (cm5_d[1] > mx5_d) mx5_d = cm5_d[1];
    if (cm5_d[2] > mx5_d) mx5_d = cm5_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cm5_q <= cm5_d;
      cn5_q <= {c4_q[2][63], c4_q[1][63], c4_q[0][63]};
      mx5_q <= mx5_d;
      ln5_q <= ln4_q;
    end
  end

  // Stage 6: shift that brings the largest magnitude under 2^30
  logic [5:0]       k6_d, k6_q;
  logic [6:0]       blen;
  logic [2:0][62:0] cm6_q;
  logic [2:0]       cn6_q;
  line_t            ln6_q;

  always_comb begin
    blen = '0;
    for (int i = 0; i < 63; i++) begin
      if (mx5_q[i]) blen = 7'(i + 1);
    end
    k6_d = (blen > 7'd30) ? 6'(blen - 7'd30) : 6'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k6_q  <= k6_d;
      cm6_q <= cm5_q;
      cn6_q <= cn5_q;
      ln6_q <= ln5_q;
    end
  end

  // Stage 7: reduced cross product
  carry_t s7_d, s7_q;
  always_comb begin
    logic [62:0] t;
    s7_d.ln    = ln6_q;
    s7_d.c_neg = cn6_q;
    t          = '0;
    for (int i = 0; i < 3; i++) begin
      t = cm6_q[i] >> k6_q;
      s7_d.c_mag[i] = t[CMAG_W-1:0];
    end
    s7_d.c_zero = (s7_d.c_mag == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) s7_q <= s7_d;
  end

  // Stage 8: squares
  logic [2:0][2*CMAG_W-1:0] sq8_q;
  carry_t                   s8_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq8_q[i] <= s7_q.c_mag[i] * s7_q.c_mag[i];
      s8_q <= s7_q;
    end
  end

  // Stage 9: sum of squares
  logic [SUM_W-1:0] sum9_q;
  carry_t           s9_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum9_q <= SUM_W'(sq8_q[0]) + SUM_W'(sq8_q[1]) + SUM_W'(sq8_q[2]);
      s9_q   <= s8_q;
    end
  end

  // Square root
  logic              sq_v;
  logic [ROOT_W-1:0] root;
  carry_t            sq_side;

  flqe_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[9]),
    .sum_i   (sum9_q),
    .side_i  (s9_q),
    .valid_o (sq_v),
    .root_o  (root),
    .side_o  (sq_side)
  );

  // Numerator |c_i| * width, denominator 2 * L
  logic                  nm_v_q;
  logic [2:0][NUM_W-1:0] num_q;
  logic [DEN_W-1:0]      den_q;
  carry_t                nm_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_v_q <= 1'b0;
    end else if (en) begin
      nm_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) num_q[i] <= sq_side.c_mag[i] * sq_side.ln.width;
      den_q     <= {root, 1'b0};
      nm_side_q <= sq_side;
    end
  end

  // Division
  logic                      dv_v;
  logic [2:0][DIV_STEPS-1:0] quot;
  carry_t                    dv_side;

  flqe_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_v_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (nm_side_q),
    .valid_o (dv_v),
    .quot_o  (quot),
    .side_o  (dv_side)
  );

  assign tail_v = dv_v;

  // ---------------- vertex serializer ----------------
  logic             ser_v_q;
  logic [2:0]       cnt_q;
  logic [2:0][31:0] sh_q;
  line_t            ser_ln_q;

  assign ser_ready = !ser_v_q || (!out_stall_i && cnt_q == 3'd5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      cnt_q   <= '0;
    end else if (tail_v && ser_ready) begin
      ser_v_q <= 1'b1;
      cnt_q   <= '0;
    end else if (ser_v_q && !out_stall_i) begin
      if (cnt_q == 3'd5) begin
        ser_v_q <= 1'b0;
        cnt_q   <= '0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_v && ser_ready) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_side.c_zero) begin
          sh_q[i] <= '0;
        end else if (dv_side.c_neg[i]) begin
          sh_q[i] <= 32'(-{1'b0, quot[i]});
        end else begin
          sh_q[i] <= {1'b0, quot[i]};
        end
      end
      ser_ln_q <= dv_side.ln;
    end
  end

  logic [1:0]       corner;
  logic [2:0][31:0] base;
  logic [2:0][31:0] vert;

  always_comb begin
    corner = CornerOrder[cnt_q];
    base   = corner[1] ? ser_ln_q.b : ser_ln_q.a;
    for (int i = 0; i < 3; i++) begin
      if (corner[0]) begin
        vert[i] = sat32({base[i][31], base[i]} + {sh_q[i][31], sh_q[i]});
      end else begin
        vert[i] = sat32({base[i][31], base[i]} - {sh_q[i][31], sh_q[i]});
      end
    end
  end

  assign out_valid_o          = ser_v_q;
  assign out_word_o.vert_x    = vert[0];
  assign out_word_o.vert_y    = vert[1];
  assign out_word_o.vert_z    = vert[2];
  assign out_word_o.color_out = {ser_ln_q.color[31:24], 1'b0, ser_ln_q.color[23:17],
                                 1'b0, ser_ln_q.color[15:9], 1'b0, ser_ln_q.color[7:1]};
  assign out_word_o.corner    = corner;
  assign out_word_o.last      = (cnt_q == 3'd5);

  // ---------------- assertions ----------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd5) else $error("vertex counter out of range");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (ser_v_q && tail_v)) else $error("stall without busy tail");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v && !dv_side.c_zero) |->
      ({1'b0, quot[0]} <= {1'b0, dv_side.ln.width[30:1]} + 32'd0 &&
       {1'b0, quot[1]} <= {1'b0, dv_side.ln.width[30:1]} + 32'd0 &&
       {1'b0, quot[2]} <= {1'b0, dv_side.ln.width[30:1]} + 32'd0))
    else $error("shift exceeds half width");

  a_load_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_v && ser_ready) |=> (ser_v_q && cnt_q == 3'd0))
    else $error("serializer did not restart on load");

endmodule

FILE: src/flqe_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
module flqe_sqrt_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [flqe_pkg::SUM_W-1:0]    sum_i,
  input  flqe_pkg::carry_t              side_i,
  output logic                          valid_o,
  output logic [flqe_pkg::ROOT_W-1:0]   root_o,
  output flqe_pkg::carry_t              side_o
);
  import flqe_pkg::*;

  logic [SQRT_STEPS-1:0] v_q;
  logic [63:0]           n_q    [SQRT_STEPS];
  logic [63:0]           r_q    [SQRT_STEPS];
  carry_t                side_q [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BitC = 64'd1 << (62 - 2 * i);
    logic [63:0] n_in, r_in, n_d, r_d;
    logic        v_in;
    carry_t      s_in;

    if (i == 0) begin : g_first
      assign n_in = {{(64-SUM_W){1'b0}}, sum_i};
      assign r_in = '0;
      assign v_in = valid_i;
      assign s_in = side_i;
    end else begin : g_next
      assign n_in = n_q[i-1];
      assign r_in = r_q[i-1];
      assign v_in = v_q[i-1];
      assign s_in = side_q[i-1];
    end

    always_comb begin
      if (n_in >= r_in + BitC) begin
        n_d = n_in - (r_in + BitC);
        r_d = (r_in >> 1) + BitC;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i]    <= n_d;
        r_q[i]    <= r_d;
        side_q[i] <= s_in;
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS-1];
  assign root_o  = r_q[SQRT_STEPS-1][ROOT_W-1:0];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule

FILE: src/flqe_div_pipe.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
module flqe_div_pipe (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [2:0][flqe_pkg::NUM_W-1:0]      num_i,
  input  logic [flqe_pkg::DEN_W-1:0]           den_i,
  input  flqe_pkg::carry_t                     side_i,
  output logic                                 valid_o,
  output logic [2:0][flqe_pkg::DIV_STEPS-1:0]  quot_o,
  output flqe_pkg::carry_t                     side_o
);
  import flqe_pkg::*;

  logic [DIV_STEPS-1:0]           v_q;
  logic [2:0][DEN_W-1:0]          rem_q  [DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0]      low_q  [DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0]      quo_q  [DIV_STEPS];
  logic [DEN_W-1:0]               den_q  [DIV_STEPS];
  carry_t                         side_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [2:0][DEN_W-1:0]     rem_in, rem_d;
    logic [2:0][DIV_STEPS-1:0] low_in, quo_in, quo_d;
    logic [DEN_W-1:0]          den_in;
    logic                      v_in;
    carry_t                    s_in;

    if (j == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = {{(DEN_W-(NUM_W-DIV_STEPS)){1'b0}},
                            num_i[l][NUM_W-1:DIV_STEPS]};
        assign low_in[l] = num_i[l][DIV_STEPS-1:0];
      end
      assign quo_in = '0;
      assign den_in = den_i;
      assign v_in   = valid_i;
      assign s_in   = side_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign v_in   = v_q[j-1];
      assign s_in   = side_q[j-1];
    end

    always_comb begin
      logic [DEN_W:0] trial;
      trial = '0;
      for (int l = 0; l < 3; l++) begin
        trial = {rem_in[l], low_in[l][DIV_STEPS-1-j]};
        if (trial >= {1'b0, den_in}) begin
          rem_d[l] = DEN_W'(trial - {1'b0, den_in});
          quo_d[l] = {quo_in[l][DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[DEN_W-1:0];
          quo_d[l] = {quo_in[l][DIV_STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        low_q[j]  <= low_in;
        quo_q[j]  <= quo_d;
        den_q[j]  <= den_in;
        side_q[j] <= s_in;
      end
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign quot_o  = quo_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule
